/* hdl/btser_pkg.sv */
package btser_pkg;

    // Default depth of the token queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Register reset values.
    localparam logic [31:0] MAGIC_WORD_RESET       = 32'h6C72_733D;
    localparam logic [7:0]  PROTOCOL_VERSION_RESET = 8'h01;

    // Header bytes of the encoded format.
    localparam logic [7:0] HDR_POS_LOW       = 8'h00;
    localparam logic [7:0] HDR_NEG_LOW       = 8'h10;
    localparam logic [7:0] HDR_VARINT        = 8'h20;
    localparam logic [7:0] HDR_ZIGZAG        = 8'h21;
    localparam logic [7:0] HDR_UNDEF         = 8'h25;
    localparam logic [7:0] HDR_BINARY        = 8'h26;
    localparam logic [7:0] HDR_ARRAY         = 8'h2B;
    localparam logic [7:0] HDR_FALSE         = 8'h3A;
    localparam logic [7:0] HDR_TRUE          = 8'h3B;
    localparam logic [7:0] HDR_ARRAYREF_LOW  = 8'h40;
    localparam logic [7:0] HDR_SHORT_BIN_LOW = 8'h60;
    localparam logic [7:0] NEG_BIAS          = 8'd32;

    // Short form limits for length headers.
    localparam logic [4:0] SHORT_BIN_LIMIT = 5'd31;
    localparam logic [3:0] ARRAYREF_LIMIT  = 4'd15;

    // Byte positions within a document start sequence.
    localparam logic [3:0] DOC_VERSION_PHASE = 4'd4;
    localparam logic [3:0] DOC_LAST_PHASE    = 4'd5;

    // Token commands.
    typedef enum logic [2:0] {
        CMD_DOC_START  = 3'd0,
        CMD_INTEGER    = 3'd1,
        CMD_STR_HEADER = 3'd2,
        CMD_STR_BYTE   = 3'd3,
        CMD_ARR_HEADER = 3'd4,
        CMD_TRUE       = 3'd5,
        CMD_FALSE      = 3'd6,
        CMD_NIL        = 3'd7
    } command_t;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_MAGIC_WORD       = 1'b0,
        CFG_PROTOCOL_VERSION = 1'b1
    } cfg_index_t;

    // How the back part turns a queued token into bytes.
    typedef enum logic [1:0] {
        KIND_SINGLE = 2'd0,
        KIND_VARINT = 2'd1,
        KIND_DOC    = 2'd2
    } kind_t;

    typedef struct packed {
        command_t           command;
        logic signed [63:0] value;
        logic [7:0]         data_byte;
    } tok_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } byte_t;

    // Classified token as held in the queue.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  hdr;
        logic [63:0] vint;
    } desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic active;
        logic pop;
    } back_status_t;

endpackage

/* hdl/btser_front.sv */
module btser_front (
    input  logic              tok_valid,
    output logic              tok_stall,
    input  btser_pkg::tok_t   tok_data,
    input  btser_pkg::q_status_t q_status,
    output logic              push,
    output btser_pkg::desc_t  desc
);
    import btser_pkg::*;

    logic [63:0] v;
    logic        neg;

    assign v   = tok_data.value;
    assign neg = v[63];

    // The queue takes a transfer whenever it has room.
    assign tok_stall = q_status.full;
    assign push      = tok_valid && !q_status.full;

    // Classify the token into a single byte, a header plus varint, or a document start.
    always_comb
    begin
        desc.kind = KIND_SINGLE;
        desc.hdr  = HDR_UNDEF;
        desc.vint = v;
        unique case (tok_data.command)
            CMD_DOC_START:
            begin
                desc.kind = KIND_DOC;
            end
            CMD_INTEGER:
            begin
                if (!neg && (v[63:4] == 60'd0))
                begin
                    desc.hdr = HDR_POS_LOW | {4'd0, v[3:0]};
                end
                else if (neg && (&v[63:4]))
                begin
                    desc.hdr = HDR_NEG_LOW | (v[7:0] + NEG_BIAS);
                end
                else if (!neg)
                begin
                    desc.kind = KIND_VARINT;
                    desc.hdr  = HDR_VARINT;
                end
                else
                begin
                    // Zigzag of a negative value is the inverse of the value shifted left.
                    desc.kind = KIND_VARINT;
                    desc.hdr  = HDR_ZIGZAG;
                    desc.vint = {~v[62:0], 1'b1};
                end
            end
            CMD_STR_HEADER:
            begin
                if ((v[63:5] == 59'd0) && (v[4:0] != SHORT_BIN_LIMIT))
                begin
                    desc.hdr = HDR_SHORT_BIN_LOW | {3'd0, v[4:0]};
                end
                else
                begin
                    desc.kind = KIND_VARINT;
                    desc.hdr  = HDR_BINARY;
                end
            end
            CMD_STR_BYTE:
            begin
                desc.hdr = tok_data.data_byte;
            end
            CMD_ARR_HEADER:
            begin
                if ((v[63:4] == 60'd0) && (v[3:0] != ARRAYREF_LIMIT))
                begin
                    desc.hdr = HDR_ARRAYREF_LOW | {4'd0, v[3:0]};
                end
                else
                begin
                    desc.kind = KIND_VARINT;
                    desc.hdr  = HDR_ARRAY;
                end
            end
            CMD_TRUE:
            begin
                desc.hdr = HDR_TRUE;
            end
            CMD_FALSE:
            begin
                desc.hdr = HDR_FALSE;
            end
            CMD_NIL:
            begin
                desc.hdr = HDR_UNDEF;
            end
        endcase
    end

endmodule

/* hdl/btser_queue.sv */
module btser_queue #(
    parameter int Depth = btser_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  btser_pkg::desc_t     push_desc,
    input  logic                 pop,
    output btser_pkg::desc_t     head,
    output btser_pkg::q_status_t q_status
);
    import btser_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    desc_t             mem_reg [Depth];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]   count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign q_status.full  = (count_reg == CntW'(Depth));
    assign q_status.empty = (count_reg == '0);
    assign head           = mem_reg[rd_ptr_reg];

    assign do_push = push && !q_status.full;
    assign do_pop  = pop && !q_status.empty;

    // Pointer and fill count update, wrapping at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

/* hdl/btser_back.sv */
module btser_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  btser_pkg::desc_t        head,
    input  btser_pkg::q_status_t    q_status,
    input  logic [31:0]             magic_word,
    input  logic [7:0]              protocol_version,
    output logic                    byte_valid,
    input  logic                    byte_stall,
    output btser_pkg::byte_t        byte_data,
    output btser_pkg::back_status_t status
);
    import btser_pkg::*;

    logic        byte_valid_reg, byte_valid_next;
    byte_t       byte_data_reg, byte_data_next;
    logic        active_reg, active_next;
    kind_t       kind_reg;
    logic [7:0]  hdr_reg;
    logic [63:0] vint_reg, vint_next;
    logic [3:0]  phase_reg, phase_next;

    kind_t       src_kind;
    logic [7:0]  src_hdr;
    logic [63:0] src_vint;
    logic [3:0]  src_phase;
    logic        load_ok;
    logic        step;
    logic        pop;
    logic [7:0]  gen_byte;
    logic        gen_last;

    // The output register frees up when empty or when its transfer completes.
    assign load_ok = !byte_valid_reg || !byte_stall;
    assign pop     = load_ok && !active_reg && !q_status.empty;
    assign step    = load_ok && (active_reg || !q_status.empty);

    // Continue the token in progress, or start on the head of the queue.
    always_comb
    begin
        if (active_reg)
        begin
            src_kind  = kind_reg;
            src_hdr   = hdr_reg;
            src_vint  = vint_reg;
            src_phase = phase_reg;
        end
        else
        begin
            src_kind  = head.kind;
            src_hdr   = head.hdr;
            src_vint  = head.vint;
            src_phase = '0;
        end
    end

    // Produce the byte for the current position within the token.
    always_comb
    begin
        gen_byte  = src_hdr;
        gen_last  = 1'b1;
        vint_next = src_vint;
        unique case (src_kind)
            KIND_SINGLE:
            begin
                gen_byte = src_hdr;
                gen_last = 1'b1;
            end
            KIND_VARINT:
            begin
                if (src_phase == '0)
                begin
                    gen_byte = src_hdr;
                    gen_last = 1'b0;
                end
                else
                begin
                    // Seven bits per byte, continuation flag while more remain.
                    gen_byte  = {(|src_vint[63:7]), src_vint[6:0]};
                    gen_last  = !(|src_vint[63:7]);
                    vint_next = {7'd0, src_vint[63:7]};
                end
            end
            KIND_DOC:
            begin
                if (src_phase < DOC_VERSION_PHASE)
                begin
                    gen_byte = 8'(magic_word >> {src_phase[1:0], 3'b000});
                    gen_last = 1'b0;
                end
                else if (src_phase == DOC_VERSION_PHASE)
                begin
                    gen_byte = protocol_version;
                    gen_last = 1'b0;
                end
                else
                begin
                    gen_byte = 8'h00;
                    gen_last = (src_phase == DOC_LAST_PHASE);
                end
            end
            default:
            begin
                gen_byte = src_hdr;
                gen_last = 1'b1;
            end
        endcase
    end

    // Next state of the output register and the sequencer.
    always_comb
    begin
        byte_valid_next = byte_valid_reg;
        byte_data_next  = byte_data_reg;
        active_next     = active_reg;
        phase_next      = phase_reg;
        if (step)
        begin
            byte_valid_next         = 1'b1;
            byte_data_next.out_byte = gen_byte;
            byte_data_next.last     = gen_last;
            active_next             = !gen_last;
            phase_next              = src_phase + 1'b1;
        end
        else if (load_ok)
        begin
            byte_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            active_reg     <= 1'b0;
        end
        else
        begin
            byte_valid_reg <= byte_valid_next;
            active_reg     <= active_next;
        end
    end

    // Payload and working registers need no reset.
    always_ff @(posedge clk)
    begin
        byte_data_reg <= byte_data_next;
        phase_reg     <= phase_next;
        if (step)
        begin
            kind_reg <= src_kind;
            hdr_reg  <= src_hdr;
            vint_reg <= vint_next;
        end
    end

    assign byte_valid    = byte_valid_reg;
    assign byte_data     = byte_data_reg;
    assign status.active = active_reg;
    assign status.pop    = pop;

endmodule

/* hdl/binary_token_serializer_top.sv */
// Path: a token accepted into the queue is held in a queue entry and then in the back-end
// output register before its first byte shows. Throughput: one output byte per cycle while
// byte_stall is low, set by the single byte-wide output register of the back-end sequencer;
// a token has from one byte (small integers, flags, string bytes) to eleven (header plus ten-byte varint).
// Reset: asynchronous and active low; it empties the token queue, drops any byte in
// flight and returns the magic word and protocol version to their defaults.
module binary_token_serializer_top #(
    parameter int QueueDepth = btser_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tok_valid,
    output logic                  tok_stall,
    input  btser_pkg::tok_t       tok_data,
    output logic                  byte_valid,
    input  logic                  byte_stall,
    output btser_pkg::byte_t      byte_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  btser_pkg::cfg_index_t cfg_index,
    input  logic [31:0]           cfg_data
);
    import btser_pkg::*;

    logic [31:0]  magic_reg, magic_next;
    logic [7:0]   version_reg, version_next;
    logic         push;
    desc_t        push_desc;
    desc_t        head;
    q_status_t    q_status;
    back_status_t back_status;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        magic_next   = magic_reg;
        version_next = version_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MAGIC_WORD:       magic_next   = cfg_data;
                CFG_PROTOCOL_VERSION: version_next = cfg_data[7:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg   <= MAGIC_WORD_RESET;
            version_reg <= PROTOCOL_VERSION_RESET;
        end
        else
        begin
            magic_reg   <= magic_next;
            version_reg <= version_next;
        end
    end

    // Front end: accept and classify tokens.
    btser_front u_front (
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_data  (tok_data),
        .q_status  (q_status),
        .push      (push),
        .desc      (push_desc)
    );

    // Queue between the two halves.
    btser_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (back_status.pop),
        .head      (head),
        .q_status  (q_status)
    );

    // Back end: emit the bytes of each token.
    btser_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head             (head),
        .q_status         (q_status),
        .magic_word       (magic_reg),
        .protocol_version (version_reg),
        .byte_valid       (byte_valid),
        .byte_stall       (byte_stall),
        .byte_data        (byte_data),
        .status           (back_status)
    );

    // A token part-way through emission always has a byte on the output.
    a_active_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
        back_status.active |-> byte_valid)
        else $error("back end active without an output byte");

    // The back end only takes from a non-empty queue.
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        back_status.pop |-> !q_status.empty)
        else $error("queue popped while empty");

    // A multi-byte token only starts from a queue entry.
    a_active_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(back_status.active) |-> $past(back_status.pop))
        else $error("back end started without taking a token");

endmodule
